>>> design/fcwc_pkg.sv
// Shared types and constants of the four-cell weight combiner.
// Used by the frame decoder, the cell bank and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcwc_pkg;

  // ascii codes seen in a reply frame
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharUpA   = 8'd65;
  localparam logic [7:0] CharUpF   = 8'd70;
  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharOne   = 8'd49;
  localparam logic [7:0] CharFour  = 8'd52;

  localparam int unsigned NumDigits = 6;
  localparam int unsigned NumCells  = 4;
  localparam int unsigned WeightW   = 22;
  localparam int unsigned TotalW    = 25;

  // decimal place value of each weight digit, most significant first
  localparam logic [16:0] PlaceValue [NumDigits] = '{
    17'd100000, 17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_POWER_HOLD     = 1'b0,
    CFG_MISS_THRESHOLD = 1'b1
  } cfg_reg_e;

  // decoded reply frame
  typedef struct packed {
    logic               seen;
    logic               digits_ok;
    logic               addr_ok;
    logic [1:0]         cell_idx;
    logic [WeightW-1:0] weight;
  } frame_info_t;

  // everything reported for one poll slot
  typedef struct packed {
    logic [2:0]               polled_cell;
    logic                     round_done;
    logic                     frame_good;
    logic signed [TotalW-1:0] total_weight;
    logic                     weight_ready;
    logic [7:0]               power_hold;
  } slot_result_t;

  // accepted weight characters are 0-9 and A-F
  function automatic logic digit_ok(input logic [7:0] c);
    return ((c >= CharZero) && (c <= CharNine)) || ((c >= CharUpA) && (c <= CharUpF));
  endfunction

  // each accepted character counts as its code minus 48 (A counts 17)
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - CharZero;
    return diff[4:0];
  endfunction

endpackage

`default_nettype wire

>>> design/four_cell_weight_combiner.sv
// Top level of the four-cell weight combiner: stream ports, configuration
// registers, input and result registers. Depends on fcwc_pkg, fcwc_frame_decode, fcwc_cell_bank.
//
// Each input transfer is one poll slot and yields exactly one output transfer.
// The block takes one slot per clock cycle while the output is not stalled; a
// slot passes through the input register, then the result register, before
// its result transfer. The whole slot - digit decode, cell update and
// four-cell sum - is worked out combinationally between those two registers.
// Backpressure on the output stalls the input register only when both
// registers are full.
`timescale 1ns / 1ps
`default_nettype none

module four_cell_weight_combiner import fcwc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slot input
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // reply_byte0 .. reply_byte7, 8 bits each
  input  wire logic        s_axis_tuser,  // reply_seen
  // slot result
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,  // polled_cell[2:0], total_weight[27:3],
                                          // weight_ready[28], power_hold[36:29], zero
  output      logic        m_axis_tlast,  // round_done
  output      logic        m_axis_tuser,  // frame_good
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic        in_vld_q;
  logic        in_seen_q;
  logic [7:0]  in_bytes_q [8];
  logic        out_vld_q;
  logic [39:0] out_data_q;
  logic        out_last_q;
  logic        out_user_q;
  logic [7:0]  hold_reload_q;
  logic [1:0]  miss_thr_q;
  logic        in_xfer, advance;

  frame_info_t  info;
  slot_result_t result;

  // handshake
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_reload_q <= 8'd20;
      miss_thr_q    <= 2'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_POWER_HOLD) begin
        hold_reload_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_MISS_THRESHOLD) begin
        miss_thr_q <= cfg_data_i[1:0];
      end
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_seen_q <= s_axis_tuser;
      for (int i = 0; i < 8; i++) begin
        in_bytes_q[i] <= s_axis_tdata[8*i +: 8];
      end
    end
  end

  fcwc_frame_decode u_decode (
    .seen_i  (in_seen_q),
    .bytes_i (in_bytes_q),
    .info_o  (info)
  );

  fcwc_cell_bank u_bank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .info_i        (info),
    .hold_reload_i (hold_reload_q),
    .miss_thr_i    (miss_thr_q),
    .result_o      (result)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'b000, result.power_hold, result.weight_ready,
                     result.total_weight, result.polled_cell};
      out_last_q <= result.round_done;
      out_user_q <= result.frame_good;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

>>> design/fcwc_frame_decode.sv
// Reply frame decoder: checks the digit characters and the cell address and
// forms the decimal weight. Combinational; depends on fcwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcwc_frame_decode import fcwc_pkg::*; (
  input  wire logic             seen_i,
  input  wire logic [7:0]       bytes_i [8],
  output frame_info_t           info_o
);

  logic [NumDigits-1:0] ok;
  logic [WeightW-1:0]   term [NumDigits];
  logic [WeightW-1:0]   weight;

  // per-digit check and place-value product
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      ok[i]   = digit_ok(bytes_i[i+2]);
      term[i] = WeightW'(digit_value(bytes_i[i+2])) * WeightW'(PlaceValue[i]);
    end
  end

  // sum of the six place terms
  always_comb begin
    weight = '0;
    for (int i = 0; i < NumDigits; i++) begin
      weight = weight + term[i];
    end
  end

  // frame summary
  always_comb begin
    info_o.seen      = seen_i;
    info_o.digits_ok = &ok;
    info_o.addr_ok   = (bytes_i[0] == CharMinus) && (bytes_i[1] >= CharOne) &&
                       (bytes_i[1] <= CharFour);
    info_o.cell_idx  = bytes_i[1][1:0] - 2'd1;
    info_o.weight    = weight;
  end

endmodule

`default_nettype wire

>>> design/fcwc_cell_bank.sv
// Cell bank: per-cell weight, present mark and miss counter, the poll index,
// the power-hold counter and the end-of-round combining. Depends on fcwc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcwc_cell_bank import fcwc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire frame_info_t  info_i,
  input  wire logic [7:0]   hold_reload_i,
  input  wire logic [1:0]   miss_thr_i,
  output slot_result_t      result_o
);

  logic [WeightW-1:0] weight_q [NumCells];
  logic [WeightW-1:0] weight_d [NumCells];
  logic [NumCells-1:0] present_q, present_d, present_upd;
  logic [1:0]          misses_q [NumCells];
  logic [1:0]          misses_d [NumCells];
  logic [1:0]          misses_upd [NumCells];
  logic [2:0]          poll_q, poll_d;
  logic                ready_q, ready_d;
  logic [7:0]          hold_q, hold_d;

  logic [TotalW-1:0]   w [NumCells];
  logic [TotalW-1:0]   full_sum, alt_sum, total;
  logic                round, is_full, is_partial;
  logic [1:0]          miss_sel;
  logic [1:0]          miss_inc;

  assign round = (poll_q == 3'd4);

  // poll index walks 1..4 and wraps
  always_comb begin
    if ((poll_q >= 3'd1) && (poll_q <= 3'd3)) begin
      poll_d = poll_q + 3'd1;
    end else begin
      poll_d = 3'd1;
    end
  end

  // power-hold reload on a reply, else count down to zero
  always_comb begin
    if (info_i.seen) begin
      hold_d = hold_reload_i;
    end else if (hold_q != 8'd0) begin
      hold_d = hold_q - 8'd1;
    end else begin
      hold_d = hold_q;
    end
  end

  // store a good, addressed reply
  always_comb begin
    weight_d    = weight_q;
    present_upd = present_q;
    misses_upd  = misses_q;
    if (info_i.seen && info_i.digits_ok && info_i.addr_ok) begin
      weight_d[info_i.cell_idx]    = info_i.weight;
      present_upd[info_i.cell_idx] = 1'b1;
      misses_upd[info_i.cell_idx]  = 2'd0;
    end
    for (int k = 0; k < NumCells; k++) begin
      w[k] = TotalW'(weight_d[k]);
    end
  end

  // classify the present pattern and pick the substitute sum
  always_comb begin
    full_sum   = w[0] + w[1] + w[2] + w[3];
    alt_sum    = '0;
    is_full    = 1'b0;
    is_partial = 1'b1;
    miss_sel   = 2'd0;
    unique case (present_upd)
      4'hF: begin
        is_full    = 1'b1;
        is_partial = 1'b0;
      end
      4'hE: begin miss_sel = 2'd0; alt_sum = (w[1] << 1) + w[2] + w[3]; end
      4'hD: begin miss_sel = 2'd1; alt_sum = (w[0] << 1) + w[2] + w[3]; end
      4'hB: begin miss_sel = 2'd2; alt_sum = w[0] + w[1] + (w[3] << 1); end
      4'h7: begin miss_sel = 2'd3; alt_sum = w[0] + w[1] + (w[2] << 1); end
      4'hC: begin miss_sel = 2'd0; alt_sum = (w[2] + w[3]) << 1; end
      4'hA: begin miss_sel = 2'd0; alt_sum = (w[1] + w[3]) << 1; end
      4'h6: begin miss_sel = 2'd0; alt_sum = (w[1] + w[2]) << 1; end
      4'h9: begin miss_sel = 2'd1; alt_sum = (w[0] + w[3]) << 1; end
      4'h5: begin miss_sel = 2'd1; alt_sum = (w[0] + w[2]) << 1; end
      4'h3: begin miss_sel = 2'd2; alt_sum = (w[0] + w[1]) << 1; end
      default: begin
        is_partial = 1'b0;
      end
    endcase
  end

  // end-of-round decision: miss counting, marks and ready flag
  always_comb begin
    present_d = present_upd;
    misses_d  = misses_upd;
    ready_d   = ready_q;
    total     = '1;
    miss_inc  = (misses_upd[miss_sel] == 2'd3) ? 2'd3 : misses_upd[miss_sel] + 2'd1;
    if (round) begin
      if (is_full) begin
        total = full_sum;
      end else if (is_partial) begin
        if (miss_inc >= miss_thr_i) begin
          misses_d[miss_sel] = 2'd0;
          total              = alt_sum;
        end else begin
          misses_d[miss_sel] = miss_inc;
        end
      end
      if (is_full || is_partial) begin
        present_d = '0;
        ready_d   = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q    <= 3'd1;
      present_q <= '0;
      ready_q   <= 1'b0;
      hold_q    <= 8'd0;
      for (int k = 0; k < NumCells; k++) begin
        weight_q[k] <= '0;
        misses_q[k] <= 2'd0;
      end
    end else if (step_i) begin
      poll_q    <= poll_d;
      present_q <= present_d;
      ready_q   <= ready_d;
      hold_q    <= hold_d;
      weight_q  <= weight_d;
      misses_q  <= misses_d;
    end
  end

  // slot report
  always_comb begin
    result_o.polled_cell  = poll_q;
    result_o.round_done   = round;
    result_o.frame_good   = info_i.seen && info_i.digits_ok;
    result_o.total_weight = $signed(total);
    result_o.weight_ready = ready_d;
    result_o.power_hold   = hold_d;
  end

endmodule

`default_nettype wire

>>> dv/tb_four_cell_weight_combiner.sv
// Testbench of four_cell_weight_combiner: directed and random poll slots with stall bursts
// on both stream sides, a slot-by-slot prediction of every result and a field-by-field check.
// Depends on fcwc_pkg and the four_cell_weight_combiner design.
`timescale 1ns / 1ps

module tb_four_cell_weight_combiner;
  import fcwc_pkg::*;

  // predicts the result of every accepted poll slot and checks the outputs against it
  class combiner_scoreboard;
    logic [7:0]  hold_reload;
    logic [1:0]  miss_limit;
    logic [2:0]  poll_cell;
    logic [21:0] cell_wgt [4];
    bit          cell_seen [4];
    logic [1:0]  cell_miss [4];
    bit          ready;
    logic [7:0]  hold_cnt;
    slot_result_t expected_slots [$];
    int unsigned mismatches;

    function new();
      hold_reload = 8'd20;
      miss_limit  = 2'd2;
      poll_cell   = 3'd1;
      for (int i = 0; i < 4; i++) begin
        cell_wgt[i]  = '0;
        cell_seen[i] = 1'b0;
        cell_miss[i] = '0;
      end
      ready       = 1'b0;
      hold_cnt    = '0;
      mismatches  = 0;
    endfunction

    function void set_config(logic [7:0] reload, logic [1:0] limit);
      hold_reload = reload;
      miss_limit  = limit;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    // one more miss for cell k, true when a substitute sum is due
    function bit miss_due(int k);
      if (cell_miss[k] < 2'd3) cell_miss[k]++;
      if (cell_miss[k] >= miss_limit) begin
        cell_miss[k] = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_slot(logic seen, logic [63:0] bytes);
      slot_result_t r;
      logic [2:0]   polled;
      logic [7:0]   c;
      logic [3:0]   mask;
      bit           good;
      bit           handled;
      int           acc;
      int           k;
      int           sum;
      int           w [4];
      polled    = poll_cell;
      poll_cell = (polled >= 3'd1 && polled <= 3'd3) ? polled + 3'd1 : 3'd1;
      good      = 1'b0;
      acc       = 0;
      sum       = -1;
      // frame decode and cell update
      if (seen) begin
        good     = 1'b1;
        hold_cnt = hold_reload;
        for (int i = 0; i < 6; i++) begin
          c = bytes[8*(i+2) +: 8];
          if (good) begin
            if ((c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70))
              acc = acc * 10 + (int'(c) - 48);
            else
              good = 1'b0;
          end
        end
        if (good && bytes[7:0] == CharMinus && bytes[15:8] >= CharOne &&
            bytes[15:8] <= CharFour) begin
          k = int'(bytes[15:8]) - int'(CharOne);
          cell_wgt[k]  = acc[21:0];
          cell_seen[k] = 1'b1;
          cell_miss[k] = '0;
        end
      end else if (hold_cnt != 8'd0) begin
        hold_cnt--;
      end
      // end of a round: combine the four cells
      if (polled == 3'd4) begin
        for (int i = 0; i < 4; i++) w[i] = int'(cell_wgt[i]);
        mask    = {cell_seen[3], cell_seen[2], cell_seen[1], cell_seen[0]};
        handled = 1'b1;
        case (mask)
          4'b1111: sum = w[0] + w[1] + w[2] + w[3];
          4'b1110: if (miss_due(0)) sum = 2 * w[1] + w[2] + w[3];
          4'b1101: if (miss_due(1)) sum = 2 * w[0] + w[2] + w[3];
          4'b1011: if (miss_due(2)) sum = w[0] + w[1] + 2 * w[3];
          4'b0111: if (miss_due(3)) sum = w[0] + w[1] + 2 * w[2];
          4'b1100: if (miss_due(0)) sum = 2 * (w[2] + w[3]);
          4'b1010: if (miss_due(0)) sum = 2 * (w[1] + w[3]);
          4'b0110: if (miss_due(0)) sum = 2 * (w[1] + w[2]);
          4'b1001: if (miss_due(1)) sum = 2 * (w[0] + w[3]);
          4'b0101: if (miss_due(1)) sum = 2 * (w[0] + w[2]);
          4'b0011: if (miss_due(2)) sum = 2 * (w[0] + w[1]);
          default: handled = 1'b0;
        endcase
        if (handled) begin
          for (int i = 0; i < 4; i++) cell_seen[i] = 1'b0;
          ready = 1'b1;
        end
      end
      r.polled_cell  = polled;
      r.round_done   = (polled == 3'd4);
      r.frame_good   = good;
      r.total_weight = sum[24:0];
      r.weight_ready = ready;
      r.power_hold   = hold_cnt;
      expected_slots.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch on %s: expected 'h%0h, got 'h%0h", $realtime, field, want, got);
    endfunction

    function void check_slot(logic [39:0] data, logic last, logic user);
      slot_result_t want;
      if (expected_slots.size() == 0) begin
        report("unexpected result transfer", 32'd0, {24'd0, data[7:0]});
        return;
      end
      want = expected_slots.pop_front();
      if (data[2:0] !== want.polled_cell)
        report("polled_cell", 32'(want.polled_cell), 32'(data[2:0]));
      if (last !== want.round_done)
        report("round_done", 32'(want.round_done), 32'(last));
      if (user !== want.frame_good)
        report("frame_good", 32'(want.frame_good), 32'(user));
      if (data[27:3] !== want.total_weight)
        report("total_weight", 32'(unsigned'(want.total_weight)), 32'(data[27:3]));
      if (data[28] !== want.weight_ready)
        report("weight_ready", 32'(want.weight_ready), 32'(data[28]));
      if (data[36:29] !== want.power_hold)
        report("power_hold", 32'(want.power_hold), 32'(data[36:29]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // reply_byte0 .. reply_byte7, 8 bits each
  logic        s_axis_tuser;   // reply_seen
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // polled_cell, total_weight, weight_ready, power_hold, zero
  logic        m_axis_tlast;   // round_done
  logic        m_axis_tuser;   // frame_good
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;

  combiner_scoreboard sb = new();
  int unsigned slots_sent;
  bit          calm;
  bit          hold_req;

  four_cell_weight_combiner u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result transfers
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_slot(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 4) != 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  // accepted weight character, biased toward plain digits
  function automatic logic [7:0] weight_char();
    if ($urandom_range(0, 3) == 0) return CharUpA + 8'($urandom_range(0, 5));
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  // character outside 0-9 and A-F, often just next to an accepted range
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = CharZero - 8'd1;
      1: c = CharNine + 8'd1;
      2: c = CharUpA - 8'd1;
      3: c = CharUpF + 8'd1;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= CharZero && c <= CharNine) || (c >= CharUpA && c <= CharUpF));
      end
    endcase
    return c;
  endfunction

  function automatic logic [63:0] frame_of(int idx, string digits);
    logic [63:0] b;
    b[7:0]  = CharMinus;
    b[15:8] = CharOne + 8'(idx);
    for (int i = 0; i < 6; i++) b[8*(i+2) +: 8] = digits[i];
    return b;
  endfunction

  function automatic logic [63:0] random_frame(int idx);
    logic [63:0] b;
    b[7:0]  = CharMinus;
    b[15:8] = CharOne + 8'(idx);
    for (int i = 2; i < 8; i++) b[8*i +: 8] = weight_char();
    return b;
  endfunction

  task automatic send_slot(input logic seen, input logic [63:0] bytes);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= seen;
    s_axis_tdata  <= bytes;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_slot(seen, bytes);
    slots_sent++;
  endtask

  task automatic sender_gap(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // let every result drain, then wait with the input idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] reload, input logic [1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POWER_HOLD;
    cfg_data_i <= reload;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MISS_THRESHOLD;
    cfg_data_i <= {6'd0, limit};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_config(reload, limit);
  endtask

  // directed rounds: digit extremes, bad digits, bad addresses, zero to three cells missing
  task automatic run_directed();
    logic [63:0] b;
    // full round with all-zero, all-nine and all-F weights
    send_slot(1'b1, frame_of(0, "000000"));
    send_slot(1'b1, frame_of(1, "999999"));
    send_slot(1'b1, frame_of(2, "FFFFFF"));
    send_slot(1'b1, frame_of(3, "9A0F5B"));
    // cell 1 bad digit: one missing, below threshold
    send_slot(1'b1, frame_of(0, "12345:"));
    send_slot(1'b1, frame_of(1, "000001"));
    send_slot(1'b1, frame_of(2, "A00000"));
    send_slot(1'b1, frame_of(3, "000777"));
    // cells 1 and 2 missing: substitute sum once the miss count is reached
    send_slot(1'b0, frame_of(0, "111111"));
    send_slot(1'b1, frame_of(1, "@12345"));
    send_slot(1'b1, frame_of(2, "200000"));
    send_slot(1'b1, frame_of(3, "300000"));
    // three missing: marks are kept
    b = frame_of(0, "111111");
    b[15:8] = CharZero;
    send_slot(1'b1, b);
    b = frame_of(1, "222222");
    b[15:8] = CharFour + 8'd1;
    send_slot(1'b1, b);
    send_slot(1'b1, frame_of(2, "12G456"));
    send_slot(1'b1, frame_of(3, "400000"));
    // cell 3 has a wrong lead byte, cell 4 kept from the last round
    send_slot(1'b1, frame_of(0, "0F0F0F"));
    send_slot(1'b1, frame_of(1, "101010"));
    b = frame_of(2, "555555");
    b[7:0] = 8'h2b;
    send_slot(1'b1, b);
    send_slot(1'b0, frame_of(3, "/99999"));
    // all-ones and all-zero bytes
    send_slot(1'b1, '1);
    send_slot(1'b1, '0);
    send_slot(1'b0, '1);
    send_slot(1'b1, frame_of(3, "999999"));
  endtask

  // rounds of well-formed replies with some cells dropping out, plus noise
  task automatic run_random(input int count, input bit pressure, input bit last_phase);
    logic [63:0] b;
    logic [3:0]  dead;
    logic        seen;
    int          idx;
    int          nd;
    dead = '0;
    for (int n = 0; n < count; n++) begin
      if (pressure && n == 0) hold_req = 1'b1;
      if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      if (last_phase && n >= count / 2) calm = 1'b1;
      idx = slots_sent % 4;
      // pick a new set of silent cells now and then
      if (idx == 0 && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: nd = 0;
          4, 5, 6:    nd = 1;
          7, 8:       nd = 2;
          default:    nd = 3;
        endcase
        dead = '0;
        repeat (nd) dead[$urandom_range(0, 3)] = 1'b1;
      end
      seen = 1'b1;
      b = random_frame(idx);
      if ($urandom_range(0, 19) == 0) begin
        b    = {$urandom, $urandom};
        seen = 1'($urandom_range(0, 1));
      end else if (dead[idx]) begin
        case ($urandom_range(0, 3))
          0: seen = 1'b0;
          1: b[8*$urandom_range(2, 7) +: 8] = bad_char();
          2: b[7:0] = 8'($urandom_range(0, 255)) ^ {7'd0, 1'b1} ^ CharMinus ^ CharMinus
                      | (8'($urandom_range(0, 1)) << 7);
          default: b[15:8] = ($urandom_range(0, 1) == 0) ? CharOne - 8'($urandom_range(1, 49))
                                                      : CharFour + 8'($urandom_range(1, 203));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        b = random_frame($urandom_range(0, 3));
      end
      send_slot(seen, b);
      if (!calm && !(pressure && n < 30) && $urandom_range(0, 4) == 0)
        sender_gap($urandom_range(1, 17));
    end
  endtask

  // stimulus and final verdict
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_POWER_HOLD;
    cfg_data_i    = '0;
    slots_sent    = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();
    configure(8'd0, 2'd1);
    run_random(240, 1'b1, 1'b0);
    settle();
    configure(8'd255, 2'd3);
    run_random(240, 1'b0, 1'b0);
    settle();
    configure(8'($urandom_range(1, 254)), 2'd0);
    run_random(240, 1'b0, 1'b0);
    settle();
    configure(8'($urandom_range(0, 255)), 2'($urandom_range(1, 3)));
    run_random(240, 1'b0, 1'b0);
    settle();
    configure(8'd20, 2'd2);
    run_random(240, 1'b0, 1'b1);
    settle();
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
